### rtl/radial_noise_whitening_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radial noise whitening block
// Implication checks, same cycle and next cycle, compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RADIAL_NOISE_WHITENING_ASSERT_SVH
`define RADIAL_NOISE_WHITENING_ASSERT_SVH

`ifndef ASSERT_OFF
// hold cons in the same cycle as ante
`define RNW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// hold cons in the cycle after ante
`define RNW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define RNW_ASSERT_IMP(label, clk, rst, ante, cons)
`define RNW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/rnw_pkg.sv
// ----------------------------------------------------------------------------
// rnw_pkg
// Types, widths and constants shared by the radial noise whitening block.
// ----------------------------------------------------------------------------
`default_nettype none

package rnw_pkg;

   localparam int unsigned MAX_HALF_WIDTH_DEF = 512;

   localparam int unsigned HW_W    = 10;
   localparam int unsigned HT_W    = 11;
   localparam int unsigned IDX_W   = 9;
   localparam int unsigned COL_W   = 9;
   localparam int unsigned ROW_W   = 10;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned SROW_W  = 12;
   localparam int unsigned R2_W    = 24;
   localparam int unsigned RAD_W   = R2_W / 2;
   localparam int unsigned WH_W    = 2 * HT_W;
   localparam int unsigned PROD_W  = DATA_W + WH_W;
   localparam int unsigned SPLIT_W = 26;
   localparam int unsigned AREA_SH = 12;
   localparam int unsigned NSQ_W   = 64;
   localparam int unsigned DIV_W   = 32;
   localparam int unsigned FRAC_SH = 14;
   localparam int unsigned LANES   = 2;
   localparam int unsigned EXT_W   = 16;

   localparam logic [DATA_W-1:0] QUARTER_PI_Q32 = 32'd3373259426;
   localparam logic [DATA_W-1:0] POS_SAT        = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_SAT        = 32'h8000_0000;

   localparam logic [HW_W-1:0] HALF_WIDTH_RST   = 10'd512;
   localparam logic [HT_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH   = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_PIXEL = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                 mode;
      logic [IDX_W-1:0]         table_index;
      logic [DATA_W-1:0]        noise_power;
      logic [COL_W-1:0]         pixel_col;
      logic [ROW_W-1:0]         pixel_row;
      logic signed [DATA_W-1:0] in_real;
      logic signed [DATA_W-1:0] in_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_real;
      logic signed [DATA_W-1:0] out_imag;
      logic                     forced_zero;
   } rsp_type;

   // carried alongside the radius root
   typedef struct packed {
      mode_type          mode;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] noise;
      logic              origin;
      logic [LANES-1:0][DATA_W-1:0] value;
   } rad_side_type;

   // carried alongside the divisor root
   typedef struct packed {
      logic                         forced;
      logic [LANES-1:0][DATA_W-1:0] value;
   } sqrt_side_type;

   // carried alongside the quotients
   typedef struct packed {
      logic             forced;
      logic [LANES-1:0] neg;
      logic [LANES-1:0] zero;
      logic [LANES-1:0] ovf;
   } div_side_type;

endpackage

`default_nettype wire

### rtl/rnw_if.sv
// ----------------------------------------------------------------------------
// rnw_if
// Request and response channels: valid, ready and a payload struct.
// ----------------------------------------------------------------------------
`default_nettype none

interface rnw_req_if import rnw_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rnw_rsp_if import rnw_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/rnw_isqrt.sv
// ----------------------------------------------------------------------------
// rnw_isqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rnw_isqrt import rnw_pkg::*; #(
   parameter int unsigned WIDTH  = R2_W,
   parameter int unsigned SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [WIDTH-1:0]      in_value,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [WIDTH/2-1:0]    out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int unsigned HALF  = WIDTH / 2;
   localparam int unsigned REM_W = HALF + 2;

   logic              chain_valid [HALF+1];
   logic [WIDTH-1:0]  chain_value [HALF+1];
   logic [REM_W-1:0]  chain_rem   [HALF+1];
   logic [HALF-1:0]   chain_root  [HALF+1];
   logic [SIDE_W-1:0] chain_side  [HALF+1];

   assign chain_valid[0] = in_valid;
   assign chain_value[0] = in_value;
   assign chain_rem[0]   = '0;
   assign chain_root[0]  = '0;
   assign chain_side[0]  = in_side;

   for (genvar k = 0; k < HALF; k++) begin : g_step
      logic [REM_W+1:0]  trial_rem;
      logic [REM_W+1:0]  trial_sub;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [HALF-1:0]   root_in;
      logic              valid_ff;
      logic [WIDTH-1:0]  value_ff;
      logic [REM_W-1:0]  rem_ff;
      logic [HALF-1:0]   root_ff;
      logic [SIDE_W-1:0] side_ff;

      // bring down the next bit pair, try root*4+1
      assign trial_rem = {chain_rem[k], chain_value[k][WIDTH-1 -: 2]};
      assign trial_sub = (REM_W+2)'({chain_root[k], 2'b01});
      assign take      = trial_rem >= trial_sub;
      assign rem_in    = take ? REM_W'(trial_rem - trial_sub) : REM_W'(trial_rem);
      assign root_in   = HALF'({chain_root[k], take});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= chain_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            value_ff <= chain_value[k] << 2;
            rem_ff   <= rem_in;
            root_ff  <= root_in;
            side_ff  <= chain_side[k];
         end
      end

      assign chain_valid[k+1] = valid_ff;
      assign chain_value[k+1] = value_ff;
      assign chain_rem[k+1]   = rem_ff;
      assign chain_root[k+1]  = root_ff;
      assign chain_side[k+1]  = side_ff;
   end

   assign out_valid = chain_valid[HALF];
   assign out_root  = chain_root[HALF];
   assign out_side  = chain_side[HALF];

endmodule

`default_nettype wire

### rtl/rnw_div.sv
// ----------------------------------------------------------------------------
// rnw_div
// Pipelined restoring divider, two lanes sharing one divisor, one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rnw_div import rnw_pkg::*; #(
   parameter int unsigned SIDE_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [DIV_W-1:0]             in_den,
   input  logic [LANES-1:0][DIV_W-1:0]  in_rem,
   input  logic [LANES-1:0][DIV_W-1:0]  in_num,
   input  logic [SIDE_W-1:0]            in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][DIV_W-1:0]  out_quo,
   output logic [SIDE_W-1:0]            out_side
);

   logic                        chain_valid [DIV_W+1];
   logic [DIV_W-1:0]            chain_den   [DIV_W+1];
   logic [LANES-1:0][DIV_W-1:0] chain_rem   [DIV_W+1];
   logic [LANES-1:0][DIV_W-1:0] chain_quo   [DIV_W+1];
   logic [SIDE_W-1:0]           chain_side  [DIV_W+1];

   assign chain_valid[0] = in_valid;
   assign chain_den[0]   = in_den;
   assign chain_rem[0]   = in_rem;
   assign chain_quo[0]   = in_num;
   assign chain_side[0]  = in_side;

   for (genvar k = 0; k < DIV_W; k++) begin : g_step
      logic [LANES-1:0][DIV_W-1:0] rem_in;
      logic [LANES-1:0][DIV_W-1:0] quo_in;
      logic                        valid_ff;
      logic [DIV_W-1:0]            den_ff;
      logic [LANES-1:0][DIV_W-1:0] rem_ff;
      logic [LANES-1:0][DIV_W-1:0] quo_ff;
      logic [SIDE_W-1:0]           side_ff;

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DIV_W:0] shifted;
         logic           take;

         // shift the next numerator bit in, quotient bits fill from the bottom
         assign shifted   = {chain_rem[k][l], chain_quo[k][l][DIV_W-1]};
         assign take      = shifted >= {1'b0, chain_den[k]};
         assign rem_in[l] = take ? DIV_W'(shifted - {1'b0, chain_den[k]})
                                 : DIV_W'(shifted);
         assign quo_in[l] = {chain_quo[k][l][DIV_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= chain_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff  <= chain_den[k];
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            side_ff <= chain_side[k];
         end
      end

      assign chain_valid[k+1] = valid_ff;
      assign chain_den[k+1]   = den_ff;
      assign chain_rem[k+1]   = rem_ff;
      assign chain_quo[k+1]   = quo_ff;
      assign chain_side[k+1]  = side_ff;
   end

   assign out_valid = chain_valid[DIV_W];
   assign out_quo   = chain_quo[DIV_W];
   assign out_side  = chain_side[DIV_W];

endmodule

`default_nettype wire

### rtl/radial_noise_whitening.sv
// ----------------------------------------------------------------------------
// radial_noise_whitening
// Whitens half-plane Fourier pixels against a radial noise power table.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            carries
//   req_if    in         valid/ready          table load or pixel request
//   rsp_if    out        valid/ready          whitened pixel, forced_zero flag
//   csr_*     in         csr_wr_en only       half_width, image_height
//
// One request enters per cycle while the pipeline is not frozen. Three
// bit-serial pipelines lie on the path: 12 stages for the radius root,
// 32 for the divisor root and 32 for the divider.
// Reset clears valid bits and loads the register defaults; the noise table
// is not cleared and must be loaded before use.
// All stages freeze together only when the output register holds a result
// that is not taken and another result waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "radial_noise_whitening_assert.svh"

module radial_noise_whitening import rnw_pkg::*; #(
   parameter int unsigned MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   rnw_req_if.sink               req_if,
   rnw_rsp_if.source             rsp_if
);

   localparam int unsigned AW = $clog2(MAX_HALF_WIDTH);

   // ------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------
   logic [HW_W-1:0] half_width_ff;
   logic [HT_W-1:0] image_height_ff;
   logic [HT_W-1:0] width_odd;
   logic [WH_W-1:0] wh_in;
   logic [WH_W-1:0] wh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff   <= HALF_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:   half_width_ff   <= csr_wr_data[HW_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wr_data[HT_W-1:0];
         endcase
      end
   end

   // full width times height; a zero half width wraps, but then every pixel
   // is forced to zero anyway
   assign width_odd = {half_width_ff, 1'b0} - HT_W'(1);
   assign wh_in     = width_odd * image_height_ff;

   always_ff @(posedge clock) begin
      wh_ff <= wh_in;
   end

   // ------------------------------------------------------------------
   // flow control: freeze everything only when a result cannot leave
   // ------------------------------------------------------------------
   logic advance;
   logic dv_valid;
   logic out_valid_ff;

   assign advance      = !(out_valid_ff && !rsp_if.ready && dv_valid);
   assign req_if.ready = advance;

   // ------------------------------------------------------------------
   // stage 1: capture request, fold the row into a signed row
   // ------------------------------------------------------------------
   logic [SROW_W-1:0] srow_in;
   logic              s1_valid_ff;
   logic [SROW_W-1:0] s1_srow_ff;
   logic [COL_W-1:0]  s1_col_ff;
   rad_side_type      s1_side_ff;
   rad_side_type      s1_side_in;

   assign srow_in = ({2'b00, req_if.data.pixel_row} < {2'b00, half_width_ff})
                  ? {2'b00, req_if.data.pixel_row}
                  : {2'b00, req_if.data.pixel_row} - {1'b0, image_height_ff};

   always_comb begin
      s1_side_in.mode     = req_if.data.mode;
      s1_side_in.idx      = req_if.data.table_index;
      s1_side_in.noise    = req_if.data.noise_power;
      s1_side_in.origin   = (req_if.data.pixel_col == '0) && (req_if.data.pixel_row == '0);
      s1_side_in.value[0] = req_if.data.in_real;
      s1_side_in.value[1] = req_if.data.in_imag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_srow_ff <= srow_in;
         s1_col_ff  <= req_if.data.pixel_col;
         s1_side_ff <= s1_side_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: squared radius
   // ------------------------------------------------------------------
   logic [2*COL_W-1:0]         col_sq;
   logic signed [2*SROW_W-1:0] srow_sq;
   logic [R2_W-1:0]            r2_in;
   logic                       s2_valid_ff;
   logic [R2_W-1:0]            s2_r2_ff;
   rad_side_type               s2_side_ff;

   assign col_sq  = s1_col_ff * s1_col_ff;
   assign srow_sq = $signed(s1_srow_ff) * $signed(s1_srow_ff);
   assign r2_in   = R2_W'(col_sq) + R2_W'(unsigned'(srow_sq));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_r2_ff   <= r2_in;
         s2_side_ff <= s1_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // radius root, one bit per stage
   // ------------------------------------------------------------------
   logic             rad_valid;
   logic [RAD_W-1:0] rad_root;
   rad_side_type     rad_side;

   rnw_isqrt #(
      .WIDTH  (R2_W),
      .SIDE_W ($bits(rad_side_type))
   ) u_rad_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s2_valid_ff),
      .in_value  (s2_r2_ff),
      .in_side   (s2_side_ff),
      .out_valid (rad_valid),
      .out_root  (rad_root),
      .out_side  (rad_side)
   );

   // ------------------------------------------------------------------
   // stage 3: noise table; loads write here so that table accesses keep
   // request order
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] noise_mem [MAX_HALF_WIDTH];
   logic [EXT_W-1:0]  wr_ext;
   logic [EXT_W-1:0]  rd_ext;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic              wr_ok;
   logic              in_range;
   logic              s3_valid_ff;
   logic [DATA_W-1:0] s3_p_ff;
   logic              s3_in_range_ff;
   logic              s3_origin_ff;
   logic [LANES-1:0][DATA_W-1:0] s3_value_ff;

   assign wr_ext   = EXT_W'(rad_side.idx);
   assign rd_ext   = EXT_W'(rad_root);
   assign wr_addr  = wr_ext[AW-1:0];
   assign rd_addr  = rd_ext[AW-1:0];
   assign wr_ok    = 32'(rad_side.idx) < MAX_HALF_WIDTH;
   assign in_range = (rad_root < RAD_W'(half_width_ff)) && (32'(rad_root) < MAX_HALF_WIDTH);

   always_ff @(posedge clock) begin
      if (advance) begin
         if (rad_valid && rad_side.mode == MODE_LOAD && wr_ok) begin
            noise_mem[wr_addr] <= rad_side.noise;
         end
         s3_p_ff <= noise_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         // drop loads: they give no response
         s3_valid_ff <= rad_valid && rad_side.mode == MODE_PIXEL;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_in_range_ff <= in_range;
         s3_origin_ff   <= rad_side.origin;
         s3_value_ff    <= rad_side.value;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: power times width times height
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] power;
   logic              s4_valid_ff;
   logic [PROD_W-1:0] s4_x_ff;
   sqrt_side_type     s4_side_ff;
   sqrt_side_type     s4_side_in;

   assign power             = s3_in_range_ff ? s3_p_ff : '0;
   assign s4_side_in.forced = s3_origin_ff || (power == '0);
   assign s4_side_in.value  = s3_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_x_ff    <= power * wh_ff;
         s4_side_ff <= s4_side_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: times pi/4, split into two partial products
   // ------------------------------------------------------------------
   localparam int unsigned XH_W = PROD_W - SPLIT_W;

   logic                     s5_valid_ff;
   logic [XH_W+DATA_W-1:0]   s5_a_ff;
   logic [SPLIT_W+DATA_W-1:0] s5_b_ff;
   sqrt_side_type            s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_a_ff    <= s4_x_ff[PROD_W-1:SPLIT_W] * QUARTER_PI_Q32;
         s5_b_ff    <= s4_x_ff[SPLIT_W-1:0] * QUARTER_PI_Q32;
         s5_side_ff <= s4_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: recombine, keep floor(x*pi/4) and scale by 2^12 modulo 2^64
   // ------------------------------------------------------------------
   localparam int unsigned LOW_SH = DATA_W - SPLIT_W;
   localparam int unsigned AREA_W = NSQ_W - AREA_SH;

   logic [SPLIT_W+DATA_W:0] low_sum;
   logic [AREA_W-1:0]       area_low;
   logic                    s6_valid_ff;
   logic [NSQ_W-1:0]        s6_n_ff;
   sqrt_side_type           s6_side_ff;

   assign low_sum  = (SPLIT_W+DATA_W+1)'({s5_a_ff[LOW_SH-1:0], SPLIT_W'(0)})
                   + (SPLIT_W+DATA_W+1)'(s5_b_ff);
   assign area_low = s5_a_ff[LOW_SH +: AREA_W] + AREA_W'(low_sum[SPLIT_W+DATA_W:DATA_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_n_ff    <= {area_low, AREA_SH'(0)};
         s6_side_ff <= s5_side_ff;
      end
   end

   // ------------------------------------------------------------------
   // divisor root
   // ------------------------------------------------------------------
   logic               dsq_valid;
   logic [DIV_W-1:0]   dsq_root;
   sqrt_side_type      dsq_side;

   rnw_isqrt #(
      .WIDTH  (NSQ_W),
      .SIDE_W ($bits(sqrt_side_type))
   ) u_den_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s6_valid_ff),
      .in_value  (s6_n_ff),
      .in_side   (s6_side_ff),
      .out_valid (dsq_valid),
      .out_root  (dsq_root),
      .out_side  (dsq_side)
   );

   // ------------------------------------------------------------------
   // stage 7: magnitudes scaled by 2^14; the part above the low word is
   // the starting remainder, and one not below the divisor means the
   // quotient saturates
   // ------------------------------------------------------------------
   localparam int unsigned HI_BITS = DATA_W - FRAC_SH;

   logic [LANES-1:0][DIV_W-1:0] rem_in;
   logic [LANES-1:0][DIV_W-1:0] num_in;
   div_side_type                s7_side_in;
   logic                        s7_valid_ff;
   logic [DIV_W-1:0]            s7_den_ff;
   logic [LANES-1:0][DIV_W-1:0] s7_rem_ff;
   logic [LANES-1:0][DIV_W-1:0] s7_num_ff;
   div_side_type                s7_side_ff;

   assign s7_side_in.forced = dsq_side.forced;

   for (genvar l = 0; l < LANES; l++) begin : g_prep
      logic [DATA_W-1:0] mag;

      assign s7_side_in.neg[l]  = dsq_side.value[l][DATA_W-1];
      assign s7_side_in.zero[l] = dsq_side.value[l] == '0;
      assign mag       = s7_side_in.neg[l] ? DATA_W'(0) - dsq_side.value[l]
                                          : dsq_side.value[l];
      assign rem_in[l] = DIV_W'(mag[DATA_W-1:HI_BITS]);
      assign num_in[l] = {mag[HI_BITS-1:0], FRAC_SH'(0)};
      assign s7_side_in.ovf[l] = rem_in[l] >= dsq_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= dsq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_den_ff  <= dsq_root;
         s7_rem_ff  <= rem_in;
         s7_num_ff  <= num_in;
         s7_side_ff <= s7_side_in;
      end
   end

   // ------------------------------------------------------------------
   // divider
   // ------------------------------------------------------------------
   logic [LANES-1:0][DIV_W-1:0] dv_quo;
   div_side_type                dv_side;

   rnw_div #(
      .SIDE_W ($bits(div_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (s7_valid_ff),
      .in_den    (s7_den_ff),
      .in_rem    (s7_rem_ff),
      .in_num    (s7_num_ff),
      .in_side   (s7_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // ------------------------------------------------------------------
   // output: sign, saturate, hold in the output register
   // ------------------------------------------------------------------
   logic [LANES-1:0][DATA_W-1:0] lane_out;
   rsp_type                      rsp_in;
   rsp_type                      out_data_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_sat
      always_comb begin
         priority if (dv_side.forced || dv_side.zero[l]) begin
            lane_out[l] = '0;
         end else if (dv_side.ovf[l]) begin
            lane_out[l] = dv_side.neg[l] ? NEG_SAT : POS_SAT;
         end else if (!dv_side.neg[l]) begin
            lane_out[l] = (dv_quo[l] > POS_SAT) ? POS_SAT : dv_quo[l];
         end else begin
            lane_out[l] = (dv_quo[l] > NEG_SAT) ? NEG_SAT : DATA_W'(0) - dv_quo[l];
         end
      end
   end

   assign rsp_in.out_real    = lane_out[0];
   assign rsp_in.out_imag    = lane_out[1];
   assign rsp_in.forced_zero = dv_side.forced;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && dv_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dv_valid) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `RNW_ASSERT_IMP(a_forced_is_zero, clock, reset, rsp_if.valid && rsp_if.data.forced_zero, rsp_if.data.out_real == '0 && rsp_if.data.out_imag == '0)
   `RNW_ASSERT_NEXT(a_load_dropped, clock, reset, advance && rad_valid && rad_side.mode == MODE_LOAD, !s3_valid_ff)
   `RNW_ASSERT_NEXT(a_stall_holds, clock, reset, dv_valid && !advance, dv_valid)

endmodule

`default_nettype wire
